>>> rtl/tcce_pkg.sv
// text console character engine: shared constants and field widths
// no dependencies; used by tcce_cell_ram and text_console_character_engine_unit
package tcce_pkg;

  localparam int COLUMNS_DEF  = 80;
  localparam int ROWS_DEF     = 25;
  localparam int TAB_STOP_DEF = 8;

  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int COLR_W = 4;
  localparam int ADDR_W = 11;
  localparam int CUR_W  = 11;
  localparam int CELL_W = 16;

  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

endpackage

>>> rtl/text_console_character_engine_unit.sv
// text console character engine: cursor control and screen sweeps over one cell memory
// depends on tcce_pkg and tcce_cell_ram
//
//  channel | dir | word                                  | handshake
//  in_     | in  | tuser cmd, tdata char/colors/address  | in_tvalid / in_tready
//  out_    | out | tdata cursor, cell data, scrolled     | out_tvalid / out_tready
//
// put, read and unused commands are accepted in S_IDLE, then loaded into the result register in S_DONE
// clear blanks all ROWS*COLUMNS cells, one cell written per cycle on the memory write port
// a put that scrolls copies (ROWS-1)*COLUMNS cells one row up, then blanks the COLUMNS cells of the bottom row
// after reset a blanking pass over all ROWS*COLUMNS cells runs before the first word is taken
// a result waiting on out_tready holds the next item in S_DONE
module text_console_character_engine_unit #(
  parameter int COLUMNS  = tcce_pkg::COLUMNS_DEF,
  parameter int ROWS     = tcce_pkg::ROWS_DEF,
  parameter int TAB_STOP = tcce_pkg::TAB_STOP_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  input  logic [31:0] in_tdata,   // [7:0] char_code, [11:8] bg color, [15:12] fg color,
                                  // [26:16] cell_address, [31:27] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [10:0] cursor_position, [26:11] cell_data,
                                  // [27] scrolled, [31:28] zero
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int COPY_COUNT = (ROWS - 1) * COLUMNS;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int CW         = $clog2(COLUMNS);
  localparam int RW         = $clog2(ROWS + 1);
  localparam int CXW        = $clog2(COLUMNS + TAB_STOP + 1);
  localparam int TAB_N      = COLUMNS / TAB_STOP + 1;
  localparam int CMD_W      = tcce_pkg::CMD_W;
  localparam int CHAR_W     = tcce_pkg::CHAR_W;
  localparam int COLR_W     = tcce_pkg::COLR_W;
  localparam int ADDR_W     = tcce_pkg::ADDR_W;
  localparam int CUR_W      = tcce_pkg::CUR_W;
  localparam int CELL_W     = tcce_pkg::CELL_W;

  typedef enum logic [4:0] {
    S_INIT   = 5'b00001,
    S_IDLE   = 5'b00010,
    S_SCROLL = 5'b00100,
    S_BLANK  = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic              res_read_r, res_read_nxt;
  logic              res_scroll_r, res_scroll_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CUR_W-1:0]  out_cur_r, out_cur_nxt;
  logic [CELL_W-1:0] out_cell_r, out_cell_nxt;
  logic              out_scroll_r, out_scroll_nxt;

  logic [CMD_W-1:0]  in_cmd;
  logic [CHAR_W-1:0] in_char;
  logic [COLR_W-1:0] in_back;
  logic [COLR_W-1:0] in_fore;
  logic [ADDR_W-1:0] in_addr;
  logic              accept;
  logic              addr_ok;
  logic [AW-1:0]     cur_idx;
  logic [CXW-1:0]    col_e;
  logic [CXW-1:0]    tab_col;
  logic [RW-1:0]     row_e;
  logic              printable;
  logic              out_free;

  logic              ram_we;
  logic [AW-1:0]     ram_wa;
  logic [CELL_W-1:0] ram_wd;
  logic              ram_re;
  logic [AW-1:0]     ram_ra;
  logic [CELL_W-1:0] ram_rd;

  assign in_cmd  = in_tuser;
  assign in_char = in_tdata[7:0];
  assign in_back = in_tdata[11:8];
  assign in_fore = in_tdata[15:12];
  assign in_addr = in_tdata[26:16];

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign addr_ok   = 32'(in_addr) < CELL_COUNT;
  assign cur_idx   = AW'(32'(row_r) * COLUMNS + 32'(col_r));
  assign out_free  = !out_valid_r || out_tready;
  assign printable = (in_char >= tcce_pkg::CH_SPACE) && (in_char <= tcce_pkg::CH_DEL);

  // next tab stop: smallest multiple of the stop above the column
  always_comb begin
    tab_col = CXW'(TAB_N * TAB_STOP);
    for (int k = TAB_N; k >= 1; k--) begin
      if (CXW'(k * TAB_STOP) > CXW'(col_r)) begin
        tab_col = CXW'(k * TAB_STOP);
      end
    end
  end

  // cursor after a put, with wrap applied, before scroll
  always_comb begin
    col_e = CXW'(col_r);
    row_e = row_r;
    case (in_char) inside
      tcce_pkg::CH_BS: begin
        if (col_r != '0) begin
          col_e = CXW'(col_r) - CXW'(1);
        end
      end
      tcce_pkg::CH_TAB: col_e = tab_col;
      tcce_pkg::CH_CR:  col_e = '0;
      tcce_pkg::CH_LF: begin
        col_e = '0;
        row_e = row_r + RW'(1);
      end
      [tcce_pkg::CH_SPACE:tcce_pkg::CH_DEL]: col_e = CXW'(col_r) + CXW'(1);
      default: col_e = CXW'(col_r);
    endcase
    if (32'(col_e) >= COLUMNS) begin
      col_e = '0;
      row_e = row_e + RW'(1);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    res_read_nxt   = res_read_r;
    res_scroll_nxt = res_scroll_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_cur_nxt    = out_cur_r;
    out_cell_nxt   = out_cell_r;
    out_scroll_nxt = out_scroll_r;
    ram_we         = 1'b0;
    ram_wa         = cnt_r;
    ram_wd         = tcce_pkg::BLANK_CELL;
    ram_re         = 1'b0;
    ram_ra         = AW'(in_addr);

    unique case (state_r)
      S_INIT: begin
        ram_we  = 1'b1;
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == AW'(CELL_COUNT - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          res_read_nxt   = 1'b0;
          res_scroll_nxt = 1'b0;
          state_nxt      = S_DONE;
          case (in_cmd)
            tcce_pkg::CMD_PUT: begin
              if (printable) begin
                ram_we = 1'b1;
                ram_wa = cur_idx;
                ram_wd = {in_back, in_fore, in_char};
              end
              col_nxt = CW'(col_e);
              row_nxt = row_e;
              if (32'(row_e) == ROWS) begin
                row_nxt        = RW'(ROWS - 1);
                res_scroll_nxt = 1'b1;
                cnt_nxt        = '0;
                state_nxt      = S_SCROLL;
              end
            end
            tcce_pkg::CMD_CLEAR: begin
              col_nxt   = '0;
              row_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = S_BLANK;
            end
            tcce_pkg::CMD_READ: begin
              ram_re       = addr_ok;
              res_read_nxt = addr_ok;
            end
            default: ;
          endcase
        end
      end
      S_SCROLL: begin
        // read one row down, write the cell read last cycle one row up
        ram_we = (cnt_r != '0);
        ram_wa = cnt_r - AW'(1);
        ram_wd = ram_rd;
        ram_ra = cnt_r + AW'(COLUMNS);
        if (cnt_r != AW'(COPY_COUNT)) begin
          ram_re  = 1'b1;
          cnt_nxt = cnt_r + AW'(1);
        end else begin
          state_nxt = S_BLANK;
        end
      end
      S_BLANK: begin
        ram_we  = 1'b1;
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == AW'(CELL_COUNT - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_cur_nxt    = CUR_W'(cur_idx);
          out_cell_nxt   = res_read_r ? ram_rd : '0;
          out_scroll_nxt = res_scroll_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      cnt_r        <= '0;
      col_r        <= '0;
      row_r        <= '0;
      res_read_r   <= 1'b0;
      res_scroll_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      res_read_r   <= res_read_nxt;
      res_scroll_r <= res_scroll_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_cur_r    <= out_cur_nxt;
    out_cell_r   <= out_cell_nxt;
    out_scroll_r <= out_scroll_nxt;
  end

  tcce_cell_ram #(
    .DEPTH (CELL_COUNT),
    .AW    (AW)
  ) u_cells (
    .clk (clk),
    .we  (ram_we),
    .wa  (ram_wa),
    .wd  (ram_wd),
    .re  (ram_re),
    .ra  (ram_ra),
    .rd  (ram_rd)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_scroll_r, out_cell_r, out_cur_r};

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> (32'(col_r) < COLUMNS) && (32'(row_r) < ROWS))
    else $error("cursor outside the screen");

  a_copy_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we && ram_re |-> ram_wa != ram_ra)
    else $error("scroll copy reads and writes the same cell");

  a_scroll_to_blank: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCROLL |=> state_r == S_SCROLL || state_r == S_BLANK)
    else $error("scroll left without blanking the bottom row");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != S_IDLE)
    else $error("accepted word produced no work");

  a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && out_free |=> out_valid_r && state_r == S_IDLE)
    else $error("finished result not loaded");

endmodule

>>> rtl/tcce_cell_ram.sv
// screen cell memory: one write port, one read port, registered read data
// depends on tcce_pkg for the cell width
module tcce_cell_ram #(
  parameter int DEPTH = tcce_pkg::COLUMNS_DEF * tcce_pkg::ROWS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               wa,
  input  logic [tcce_pkg::CELL_W-1:0] wd,
  input  logic                        re,
  input  logic [AW-1:0]               ra,
  output logic [tcce_pkg::CELL_W-1:0] rd
);

  logic [tcce_pkg::CELL_W-1:0] mem [DEPTH];
  logic [tcce_pkg::CELL_W-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_r <= mem[ra];
    end
  end

  assign rd = rd_r;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// testbench for text_console_character_engine_unit: puts, clears, cell reads and unused words
// each result word is checked against a mirror of the screen and cursor; needs tcce_pkg and rtl
module testbench;

  localparam int CELLS = tcce_pkg::ROWS_DEF * tcce_pkg::COLUMNS_DEF;
  localparam int COLS = tcce_pkg::COLUMNS_DEF;
  localparam int CMD_W = tcce_pkg::CMD_W;
  localparam int CHAR_W = tcce_pkg::CHAR_W;
  localparam int COLR_W = tcce_pkg::COLR_W;
  localparam int ADDR_W = tcce_pkg::ADDR_W;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
  localparam logic [CHAR_W-1:0] CH_ESC = 8'h1B;
  localparam int STALL_LIMIT = 20000;
  localparam int PHASE_WORDS = 250;

  typedef struct packed {
    logic [tcce_pkg::CUR_W-1:0]  cursor;
    logic [tcce_pkg::CELL_W-1:0] cell_data;
    logic                        scrolled;
  } console_status_t;

  class console_mirror_t;
    logic [tcce_pkg::CELL_W-1:0] screen [CELLS];
    int col;
    int row;
    int mismatches;
    console_status_t pending_status [$];

    function new();
      mismatches = 0;
      home_and_blank();
    endfunction

    function void home_and_blank();
      foreach (screen[i]) screen[i] = tcce_pkg::BLANK_CELL;
      col = 0;
      row = 0;
    endfunction

    function void apply_word(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] code,
                             logic [COLR_W-1:0] back, logic [COLR_W-1:0] fore,
                             logic [ADDR_W-1:0] addr);
      console_status_t st;
      int idx;
      st = '0;
      case (cmd)
        tcce_pkg::CMD_PUT: begin
          if (code == tcce_pkg::CH_BS) begin
            if (col != 0) col--;
          end else if (code == tcce_pkg::CH_TAB) begin
            col = col + tcce_pkg::TAB_STOP_DEF - col % tcce_pkg::TAB_STOP_DEF;
          end else if (code == tcce_pkg::CH_CR) begin
            col = 0;
          end else if (code == tcce_pkg::CH_LF) begin
            col = 0;
            row++;
          end else if (code >= tcce_pkg::CH_SPACE && code <= tcce_pkg::CH_DEL) begin
            idx = row * COLS + col;
            if (idx < CELLS) screen[idx] = {back, fore, code};
            col++;
          end
          if (col >= COLS) begin
            col = 0;
            row++;
          end
          if (row >= tcce_pkg::ROWS_DEF) begin
            for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
            for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = tcce_pkg::BLANK_CELL;
            row = tcce_pkg::ROWS_DEF - 1;
            st.scrolled = 1'b1;
          end
        end
        tcce_pkg::CMD_CLEAR: home_and_blank();
        tcce_pkg::CMD_READ: begin
          if (addr < CELLS) st.cell_data = screen[addr];
        end
        default: ;
      endcase
      st.cursor = tcce_pkg::CUR_W'(row * COLS + col);
      pending_status.push_back(st);
    endfunction

    task log_mismatch(string what);
      $display("%0t ns: %s", $time, what);
      mismatches++;
    endtask

    task check_word(logic [31:0] word);
      console_status_t want;
      if (pending_status.size() == 0) begin
        log_mismatch($sformatf("result word %h with nothing pending", word));
      end else begin
        want = pending_status.pop_front();
        if (word[10:0] != want.cursor)
          log_mismatch($sformatf("cursor %0d, want %0d", word[10:0], want.cursor));
        if (word[26:11] != want.cell_data)
          log_mismatch($sformatf("cell data %h, want %h", word[26:11], want.cell_data));
        if (word[27] != want.scrolled)
          log_mismatch($sformatf("scrolled %b, want %b", word[27], want.scrolled));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = '0;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  console_mirror_t mirror;
  int words_taken = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  text_console_character_engine_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      mirror.apply_word(in_tuser, in_tdata[7:0], in_tdata[11:8], in_tdata[15:12],
                        in_tdata[26:16]);
      words_taken <= words_taken + 1;
    end
    if (rst_n && out_tvalid && out_tready) mirror.check_word(out_tdata);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("text_console_character_engine_unit: mismatch");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after the word is taken
  task send_word(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] code, logic [COLR_W-1:0] back,
                 logic [COLR_W-1:0] fore, logic [ADDR_W-1:0] addr);
    int seen;
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {5'b0, addr, fore, back, code};
    seen = words_taken;
    do @(negedge clk); while (words_taken == seen);
  endtask

  task put_char(logic [CHAR_W-1:0] code);
    send_word(tcce_pkg::CMD_PUT, code, COLR_W'($urandom_range(15)),
              COLR_W'($urandom_range(15)), ADDR_W'($urandom_range(2047)));
  endtask

  task read_cell(logic [ADDR_W-1:0] addr);
    send_word(tcce_pkg::CMD_READ, CHAR_W'($urandom_range(255)), COLR_W'($urandom_range(15)),
              COLR_W'($urandom_range(15)), addr);
  endtask

  task random_words(int count);
    int sent;
    int r;
    int n;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(999);
      if (r < 15) begin
        // tab out to the right margin, then type across it
        put_char(tcce_pkg::CH_CR);
        repeat (9) put_char(tcce_pkg::CH_TAB);
        n = $urandom_range(6, 10);
        repeat (n) put_char(CHAR_W'($urandom_range(tcce_pkg::CH_SPACE, tcce_pkg::CH_DEL)));
        sent += 10 + n;
      end else begin
        if (r < 19) begin
          send_word(tcce_pkg::CMD_CLEAR, CHAR_W'($urandom_range(255)),
                    COLR_W'($urandom_range(15)), COLR_W'($urandom_range(15)),
                    ADDR_W'($urandom_range(2047)));
        end else if (r < 40) begin
          send_word(CMD_UNUSED, CHAR_W'($urandom_range(255)),
                    COLR_W'($urandom_range(15)), COLR_W'($urandom_range(15)),
                    ADDR_W'($urandom_range(2047)));
        end else if (r < 360) begin
          if (r < 200)
            read_cell(ADDR_W'(mirror.row * COLS + $urandom_range(COLS - 1)));
          else if (r < 260 && mirror.row > 0)
            read_cell(ADDR_W'((mirror.row - 1) * COLS + $urandom_range(COLS - 1)));
          else
            read_cell(ADDR_W'($urandom_range(2047)));
        end else begin
          r = $urandom_range(99);
          if (r < 62) put_char(CHAR_W'($urandom_range(tcce_pkg::CH_SPACE, tcce_pkg::CH_DEL)));
          else if (r < 80) put_char(tcce_pkg::CH_LF);
          else if (r < 87) put_char(tcce_pkg::CH_TAB);
          else if (r < 91) put_char(tcce_pkg::CH_CR);
          else if (r < 96) put_char(tcce_pkg::CH_BS);
          else if (r < 98) put_char(CHAR_W'($urandom_range(8'h80, 8'hFF)));
          else put_char(CHAR_W'($urandom_range(CH_NUL, tcce_pkg::CH_SPACE - 1)));
        end
        sent++;
      end
    end
  endtask

  initial begin
    mirror = new();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 30;
    recv_idle_pct = 70;

    read_cell('0);
    read_cell(ADDR_W'(CELLS - 1));
    read_cell(ADDR_W'(CELLS));
    read_cell('1);
    send_word(tcce_pkg::CMD_PUT, 8'h41, '0, '0, '0);
    send_word(tcce_pkg::CMD_PUT, tcce_pkg::CH_DEL, '1, '1, '1);
    send_word(tcce_pkg::CMD_PUT, tcce_pkg::CH_SPACE, 4'h5, 4'hA, 11'h2AA);
    put_char(tcce_pkg::CH_BS);
    put_char(tcce_pkg::CH_TAB);
    put_char(tcce_pkg::CH_CR);
    put_char(tcce_pkg::CH_BS);
    put_char(tcce_pkg::CH_LF);
    put_char(8'h80);
    put_char(8'hFF);
    put_char(CH_NUL);
    put_char(CH_ESC);
    send_word(CMD_UNUSED, '1, '1, '1, '1);
    read_cell(11'd0);
    read_cell(11'd1);
    read_cell(11'd2);
    read_cell(ADDR_W'(COLS));
    send_word(tcce_pkg::CMD_CLEAR, '0, '0, '0, '0);
    read_cell(11'd0);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 70 : 0;
      recv_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 30 : 0;
      random_words(PHASE_WORDS);
    end

    in_tvalid <= 1'b0;
    while (mirror.pending_status.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mirror.mismatches == 0)
      $display("text_console_character_engine_unit: match");
    else
      $display("text_console_character_engine_unit: mismatch");
    $finish;
  end

endmodule

>>> text_console_character_engine_unit.f
rtl/tcce_pkg.sv
rtl/tcce_cell_ram.sv
rtl/text_console_character_engine_unit.sv
verif/testbench.sv
